@@ rtl/core/cpcu_pkg.sv @@
// Package for the CIGAR profile count update unit.
// Holds field widths, operation and status codes and the control structs.
// No dependencies.
package cpcu_pkg;

   localparam int MAX_COLUMNS = 32768;
   localparam int SYMBOLS     = 5;
   localparam int STORE_DEPTH = MAX_COLUMNS * SYMBOLS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam int FUNC_W     = 2;
   localparam int COL_W      = 15;
   localparam int SYM_W      = 3;
   localparam int CNT_W      = 32;
   localparam int OP_W       = 4;
   localparam int RUN_W      = 28;
   localparam int QLEN_W     = 24;
   localparam int PLEN_W     = 16;
   localparam int STATUS_W   = 3;
   localparam int TOTAL_W    = 32;

   localparam int REQ_DATA_W = 112;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_USER_W = 1;

   localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_STEP = 2'd2;

   localparam logic [OP_W-1:0] OP_M  = 4'd0;
   localparam logic [OP_W-1:0] OP_I  = 4'd1;
   localparam logic [OP_W-1:0] OP_D  = 4'd2;
   localparam logic [OP_W-1:0] OP_N  = 4'd3;
   localparam logic [OP_W-1:0] OP_S  = 4'd4;
   localparam logic [OP_W-1:0] OP_H  = 4'd5;
   localparam logic [OP_W-1:0] OP_P  = 4'd6;
   localparam logic [OP_W-1:0] OP_EQ = 4'd7;
   localparam logic [OP_W-1:0] OP_X  = 4'd8;

   localparam logic [STATUS_W-1:0] STAT_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_REF_OVER     = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_QRY_OVER     = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_BAD_OP       = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_LEN_MISMATCH = 3'd4;

   localparam logic [SYM_W-1:0] SLOT_N = 3'd4;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [COL_W-1:0]  column;
      logic [SYM_W-1:0]  symbol;
      logic [CNT_W-1:0]  count_value;
      logic [OP_W-1:0]   op;
      logic [RUN_W-1:0]  run_length;
      logic [SYM_W-1:0]  base;
      logic [QLEN_W-1:0] query_length;
      logic              first;
      logic              last;
   } cpcu_req_type;

   typedef struct packed {
      logic                is_read_reply;
      logic [CNT_W-1:0]    read_value;
      logic                update_ok;
      logic [STATUS_W-1:0] status;
      logic [TOTAL_W-1:0]  sequences_counted;
   } cpcu_rsp_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic finish;
      logic emit;
   } cpcu_cmd_type;

   typedef struct packed {
      logic need_memory;
      logic has_result;
      logic out_free;
   } cpcu_status_type;

endpackage

@@ rtl/core/cpcu_ctrl.sv @@
// Sequencer of the CIGAR profile count update unit.
// Steps each request through an execute phase and, as needed, memory and result phases; uses cpcu_pkg.
module cpcu_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  cpcu_pkg::cpcu_status_type status,
   output cpcu_pkg::cpcu_cmd_type    cmd
);
   import cpcu_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_MEM  = 4'b0100,
      S_EMIT = 4'b1000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            if (status.need_memory) begin
               state_in = S_MEM;
            end else if (status.has_result) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MEM: begin
            cmd.finish = 1'b1;
            state_in   = status.has_result ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/cpcu_datapath.sv @@
// Datapath of the CIGAR profile count update unit: count memory, alignment
// position registers, verdict logic and the result register. Uses cpcu_pkg.
module cpcu_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  cpcu_pkg::cpcu_cmd_type         cmd,
   output cpcu_pkg::cpcu_status_type      status,
   input  cpcu_pkg::cpcu_req_type         req_in,
   input  logic                           csr_write_enable,
   input  logic [cpcu_pkg::PLEN_W-1:0]    csr_write_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output cpcu_pkg::cpcu_rsp_type         rsp_out
);
   import cpcu_pkg::*;

   cpcu_req_type        req_ff;
   cpcu_rsp_type        res_ff, rsp_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PLEN_W-1:0]   plen_ff;
   logic [PLEN_W-1:0]   ref_ff, ref_cur, ref_in;
   logic [QLEN_W-1:0]   qpos_ff, qpos_cur, qpos_in;
   logic [QLEN_W-1:0]   qlim_ff, qlim_cur;
   logic [STATUS_W-1:0] fail_ff, fail_cur, fail_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [ADDR_W-1:0]   addr_ff;
   logic [CNT_W-1:0]    rd_data_ff;
   logic [CNT_W-1:0]    mem [STORE_DEPTH];

   logic                is_load, is_read, is_step;
   logic                addr_in_range;
   logic [ADDR_W-1:0]   access_addr, match_addr;
   logic [SYM_W-1:0]    match_slot;
   logic                inc_req;
   logic                verdict_ok;
   logic [STATUS_W-1:0] verdict_status;
   logic [RUN_W:0]      ref_sum, qpos_sum;
   logic                mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0]   mem_wr_addr, mem_rd_addr;
   logic [CNT_W-1:0]    mem_wr_data;

   assign is_load = (req_ff.func == FUNC_LOAD);
   assign is_read = (req_ff.func == FUNC_READ);
   assign is_step = (req_ff.func == FUNC_STEP);

   assign addr_in_range = (32'(req_ff.column) < 32'(MAX_COLUMNS)) &&
                          (32'(req_ff.symbol) < 32'(SYMBOLS));
   assign access_addr = ADDR_W'(req_ff.column) * ADDR_W'(SYMBOLS) + ADDR_W'(req_ff.symbol);

   assign ref_cur  = req_ff.first ? '0 : ref_ff;
   assign qpos_cur = req_ff.first ? '0 : qpos_ff;
   assign qlim_cur = req_ff.first ? req_ff.query_length : qlim_ff;
   assign fail_cur = req_ff.first ? STAT_OK : fail_ff;

   assign match_slot = (32'(req_ff.base) < 32'(SYMBOLS)) ? req_ff.base : SLOT_N;
   assign match_addr = ADDR_W'(ref_cur) * ADDR_W'(SYMBOLS) + ADDR_W'(match_slot);
   assign ref_sum    = (RUN_W+1)'(ref_cur) + (RUN_W+1)'(req_ff.run_length);
   assign qpos_sum   = (RUN_W+1)'(qpos_cur) + (RUN_W+1)'(req_ff.run_length);

   always_comb begin
      ref_in  = ref_cur;
      qpos_in = qpos_cur;
      fail_in = fail_cur;
      inc_req = 1'b0;
      if (fail_cur == STAT_OK) begin
         case (req_ff.op) inside
            OP_M, OP_EQ, OP_X: begin
               if ((ref_cur >= plen_ff) || (32'(ref_cur) >= 32'(MAX_COLUMNS))) begin
                  fail_in = STAT_REF_OVER;
               end else if (qpos_cur >= qlim_cur) begin
                  fail_in = STAT_QRY_OVER;
               end else begin
                  inc_req = 1'b1;
                  ref_in  = ref_cur + 1'b1;
                  qpos_in = qpos_cur + 1'b1;
               end
            end
            OP_D, OP_N: begin
               if (ref_sum > (RUN_W+1)'(plen_ff)) begin
                  fail_in = STAT_REF_OVER;
               end else begin
                  ref_in = ref_sum[PLEN_W-1:0];
               end
            end
            OP_I, OP_S: begin
               if (qpos_sum > (RUN_W+1)'(qlim_cur)) begin
                  fail_in = STAT_QRY_OVER;
               end else begin
                  qpos_in = qpos_sum[QLEN_W-1:0];
               end
            end
            OP_H, OP_P: begin
            end
            default: begin
               fail_in = STAT_BAD_OP;
            end
         endcase
      end
   end

   always_comb begin
      total_in       = total_ff;
      verdict_ok     = 1'b0;
      verdict_status = STAT_OK;
      if (req_ff.last) begin
         if (fail_in != STAT_OK) begin
            verdict_status = fail_in;
         end else if (ref_in != plen_ff) begin
            verdict_status = STAT_LEN_MISMATCH;
         end else begin
            verdict_ok = 1'b1;
            if (total_ff != '1) begin
               total_in = total_ff + 1'b1;
            end
         end
      end
   end

   assign status.need_memory = (is_read && addr_in_range) || (is_step && inc_req);
   assign status.has_result  = is_read || (is_step && req_ff.last);
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   assign mem_rd_en   = cmd.execute && status.need_memory;
   assign mem_rd_addr = is_step ? match_addr : access_addr;
   assign mem_wr_en   = (cmd.execute && is_load && addr_in_range) || (cmd.finish && is_step);
   assign mem_wr_addr = cmd.execute ? access_addr : addr_ff;
   assign mem_wr_data = cmd.execute ? req_ff.count_value :
                        ((rd_data_ff == '1) ? rd_data_ff : rd_data_ff + 1'b1);

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_in;
      end
      if (cmd.execute) begin
         addr_ff <= mem_rd_addr;
         if (is_read) begin
            res_ff <= '{is_read_reply: 1'b1, read_value: '0, update_ok: 1'b0,
                        status: STAT_OK, sequences_counted: '0};
         end else begin
            res_ff <= '{is_read_reply: 1'b0, read_value: '0, update_ok: verdict_ok,
                        status: verdict_status, sequences_counted: total_in};
         end
      end
      if (cmd.finish && is_read) begin
         res_ff.read_value <= rd_data_ff;
      end
      if (cmd.emit) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff      <= '0;
         ref_ff       <= '0;
         qpos_ff      <= '0;
         qlim_ff      <= '0;
         fail_ff      <= STAT_OK;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            plen_ff <= csr_write_data;
         end
         if (cmd.execute && is_step) begin
            ref_ff   <= ref_in;
            qpos_ff  <= qpos_in;
            qlim_ff  <= qlim_cur;
            fail_ff  <= fail_in;
            total_ff <= total_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out   = rsp_ff;

endmodule

@@ rtl/core/cigar_profile_count_update_unit.sv @@
// CIGAR profile count update unit: keeps a per-column base-count profile,
// loads and reads it back and adds CIGAR alignment records to it.
// The request channel (req_) carries load, read and alignment-step requests;
// req_tuser selects which. The response channel (rsp_) returns a read reply
// or, on the last step of a record, its verdict; loads and other steps give
// no response. The profile length register is written through csr_write_*;
// the user must do so only while the unit is idle; the unit does not enforce it.
// One request is in work at a time. A request that needs no count memory
// access goes from the execute state to idle, or to the emit state if it
// has a response; a read or match step that touches the count memory passes
// the memory state between them. The emit state loads the output register
// once it is free. The memory state is there because the count memory read
// is registered ahead of the read-modify-write of a count.
// A pending response sits in the output register; the next request is still
// taken and worked on, but a second response waits in the unit until the
// first is taken, and no request is taken meanwhile.
// Reset clears the positions, the failure code, the record total, the
// profile length and the response valid flag. The count memory is not cleared;
// every entry must be loaded before it is read or counted.
module cigar_profile_count_update_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // column[14:0], symbol[17:15], count_value[49:18], op[53:50],
   // run_length[81:54], base[84:82], query_length[108:85], first[109]
   input  logic [cpcu_pkg::REQ_DATA_W-1:0]   req_tdata,
   // func[1:0]
   input  logic [cpcu_pkg::REQ_USER_W-1:0]   req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // read_value[31:0], update_ok[32], status[35:33], sequences_counted[67:36]
   output logic [cpcu_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // is_read_reply[0]
   output logic [cpcu_pkg::RSP_USER_W-1:0]   rsp_tuser,
   input  logic                              csr_write_enable,
   input  logic [cpcu_pkg::PLEN_W-1:0]       csr_write_data
);
   import cpcu_pkg::*;

   cpcu_req_type    req_fields;
   cpcu_rsp_type    rsp_fields;
   cpcu_cmd_type    cmd;
   cpcu_status_type dp_status;

   assign req_fields.func         = req_tuser[FUNC_W-1:0];
   assign req_fields.column       = req_tdata[14:0];
   assign req_fields.symbol       = req_tdata[17:15];
   assign req_fields.count_value  = req_tdata[49:18];
   assign req_fields.op           = req_tdata[53:50];
   assign req_fields.run_length   = req_tdata[81:54];
   assign req_fields.base         = req_tdata[84:82];
   assign req_fields.query_length = req_tdata[108:85];
   assign req_fields.first        = req_tdata[109];
   assign req_fields.last         = req_tlast;

   cpcu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (dp_status),
      .cmd       (cmd)
   );

   cpcu_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (dp_status),
      .req_in           (req_fields),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp_out          (rsp_fields)
   );

   assign rsp_tdata = RSP_DATA_W'({rsp_fields.sequences_counted, rsp_fields.status,
                                   rsp_fields.update_ok, rsp_fields.read_value});
   assign rsp_tuser = rsp_fields.is_read_reply;

`ifndef SYNTHESIS
   a_one_request_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in work");

   a_response_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("response raised straight from idle");

   a_read_reply_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_fields.is_read_reply |->
         !rsp_fields.update_ok && rsp_fields.status == STAT_OK &&
         rsp_fields.sequences_counted == '0)
      else $error("read reply carries verdict fields");

   a_verdict_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_fields.is_read_reply |->
         rsp_fields.read_value == '0 &&
         (!rsp_fields.update_ok || rsp_fields.status == STAT_OK))
      else $error("verdict fields inconsistent");
`endif

endmodule
